// File: src/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SKVT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define SKVT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define SKVT_ASSERT(label, clk, rst_n, prop)
`define SKVT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// File: src/skvt_pkg.sv
package skvt_pkg;

    localparam int KEY_W            = 32;
    localparam int VAL_W            = 64;
    localparam int DEFAULT_CAPACITY = 16;

    typedef enum logic [1:0] {
        FUNC_INSERT,
        FUNC_REMOVE,
        FUNC_FIND,
        FUNC_CLEAR
    } func_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_FAIL,
        ST_FULL
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } state_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic                    cmp_en;
        logic                    upd_en;
        logic                    hit;
        logic                    full;
        func_t                   func;
        logic signed [KEY_W-1:0] key;
        logic [VAL_W-1:0]        payload;
    } cell_cmd_t;

endpackage

// File: src/skvt_if.sv
interface skvt_in_if
    import skvt_pkg::*;
();
    logic                    valid;
    logic                    ready;
    func_t                   func;
    logic signed [KEY_W-1:0] key;
    logic [VAL_W-1:0]        payload;

    modport source (output valid, func, key, payload, input ready);
    modport sink   (input valid, func, key, payload, output ready);
endinterface

interface skvt_out_if
    import skvt_pkg::*;
();
    logic             valid;
    logic             ready;
    status_t          status;
    logic [VAL_W-1:0] found_value;

    modport source (output valid, status, found_value, input ready);
    modport sink   (input valid, status, found_value, output ready);
endinterface

// File: src/sorted_key_value_table.sv
// channel | dir | payload                          | handshake
// req     | in  | func[1:0] key[31:0] payload[63:0] | valid/ready
// rsp     | out | status[1:0] found_value[63:0]     | valid/ready
//
// each word passes a compare step, in which every cell compares its key, then an
// update step, in which the cells shift away from the insert point or toward the
// removed key (or empty on a clear) while the result goes to the output register.
// reset empties all cells at once through their valid flags; no clearing pass.
// a result word that is not taken holds the table in its update step and the
// next request word waits.
`include "assert_macros.svh"

module sorted_key_value_table
    import skvt_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic       clk,
    input  logic       rst_n,
    skvt_in_if.sink    req,
    skvt_out_if.source rsp
);

    cell_cmd_t               cmd;
    logic signed [KEY_W-1:0] cell_key   [CAPACITY];
    logic [VAL_W-1:0]        cell_val   [CAPACITY];
    logic [CAPACITY-1:0]     cell_valid;
    logic [CAPACITY-1:0]     cell_lt;
    logic [CAPACITY-1:0]     cell_eq;
    logic                    hit;
    logic                    full;
    logic [VAL_W-1:0]        found;
    logic [CAPACITY:0]       valid_ext;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic signed [KEY_W-1:0] l_key, r_key;
            logic [VAL_W-1:0]        l_val, r_val;
            logic                    l_valid, l_lt, r_valid;

            if (i == 0)
            begin : g_first
                assign l_key   = '0;
                assign l_val   = '0;
                assign l_valid = 1'b0;
                assign l_lt    = 1'b1;
            end
            else
            begin : g_mid_l
                assign l_key   = cell_key[i-1];
                assign l_val   = cell_val[i-1];
                assign l_valid = cell_valid[i-1];
                assign l_lt    = cell_lt[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign r_key   = '0;
                assign r_val   = '0;
                assign r_valid = 1'b0;
            end
            else
            begin : g_mid_r
                assign r_key   = cell_key[i+1];
                assign r_val   = cell_val[i+1];
                assign r_valid = cell_valid[i+1];
            end

            skvt_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmd         (cmd),
                .left_key    (l_key),
                .left_val    (l_val),
                .left_valid  (l_valid),
                .left_lt     (l_lt),
                .right_key   (r_key),
                .right_val   (r_val),
                .right_valid (r_valid),
                .key         (cell_key[i]),
                .val         (cell_val[i]),
                .valid       (cell_valid[i]),
                .lt          (cell_lt[i]),
                .eq          (cell_eq[i])
            );
        end
    endgenerate

    assign hit  = |cell_eq;
    assign full = cell_valid[CAPACITY-1];

    always_comb
    begin
        found = '0;
        for (int j = 0; j < CAPACITY; j++)
            found = found | (cell_val[j] & {VAL_W{cell_eq[j]}});
    end

    skvt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .hit   (hit),
        .full  (full),
        .found (found),
        .cmd   (cmd)
    );

    assign valid_ext = {1'b0, cell_valid};

    // occupied cells always form a run from cell zero
    `SKVT_ASSERT(a_valid_prefix, clk, rst_n, ((valid_ext + (CAPACITY+1)'(1)) & valid_ext) == '0)
    // keys are unique, so at most one cell matches
    `SKVT_ASSERT(a_single_match, clk, rst_n, $onehot0(cell_eq))
    // a cell is never both below and equal to the key
    `SKVT_NEVER(a_lt_eq_excl, clk, rst_n, |(cell_lt & cell_eq))

endmodule

// File: src/skvt_cell.sv
module skvt_cell
    import skvt_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cell_cmd_t               cmd,
    input  logic signed [KEY_W-1:0] left_key,
    input  logic [VAL_W-1:0]        left_val,
    input  logic                    left_valid,
    input  logic                    left_lt,
    input  logic signed [KEY_W-1:0] right_key,
    input  logic [VAL_W-1:0]        right_val,
    input  logic                    right_valid,
    output logic signed [KEY_W-1:0] key,
    output logic [VAL_W-1:0]        val,
    output logic                    valid,
    output logic                    lt,
    output logic                    eq
);

    logic signed [KEY_W-1:0] key_reg, key_next;
    logic [VAL_W-1:0]        val_reg, val_next;
    logic                    valid_reg, valid_next;
    logic                    lt_reg, lt_next;
    logic                    eq_reg, eq_next;
    logic                    do_ins, do_rem;

    assign do_ins = cmd.upd_en && (cmd.func == FUNC_INSERT) && !cmd.hit && !cmd.full;
    assign do_rem = cmd.upd_en && (cmd.func == FUNC_REMOVE) && cmd.hit;

    always_comb
    begin
        lt_next    = lt_reg;
        eq_next    = eq_reg;
        key_next   = key_reg;
        val_next   = val_reg;
        valid_next = valid_reg;
        if (cmd.cmp_en)
        begin
            lt_next = valid_reg && (key_reg < cmd.key);
            eq_next = valid_reg && (key_reg == cmd.key);
        end
        if (do_ins && !lt_reg)
        begin
            if (left_lt)
            begin
                // insertion point
                key_next   = cmd.key;
                val_next   = cmd.payload;
                valid_next = 1'b1;
            end
            else
            begin
                key_next   = left_key;
                val_next   = left_val;
                valid_next = left_valid;
            end
        end
        else if (do_rem && !lt_reg)
        begin
            key_next   = right_key;
            val_next   = right_val;
            valid_next = right_valid;
        end
        else if (cmd.upd_en && (cmd.func == FUNC_CLEAR))
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            lt_reg    <= 1'b0;
            eq_reg    <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            lt_reg    <= lt_next;
            eq_reg    <= eq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        val_reg <= val_next;
    end

    assign key   = key_reg;
    assign val   = val_reg;
    assign valid = valid_reg;
    assign lt    = lt_reg;
    assign eq    = eq_reg;

endmodule

// File: src/skvt_ctrl.sv
`include "assert_macros.svh"

module skvt_ctrl
    import skvt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    skvt_in_if.sink          req,
    skvt_out_if.source       rsp,
    input  logic             hit,
    input  logic             full,
    input  logic [VAL_W-1:0] found,
    output cell_cmd_t        cmd
);

    state_t                  state_reg, state_next;
    func_t                   func_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0]        payload_reg;
    logic                    out_valid_reg, out_valid_next;
    status_t                 status_reg, status_next;
    logic [VAL_W-1:0]        value_reg, value_next;
    logic                    can_finish;
    logic                    accept;
    logic                    upd_en;

    assign can_finish = !out_valid_reg || rsp.ready;
    assign accept     = req.valid && req.ready;

    always_comb
    begin
        state_next = state_reg;
        req.ready  = 1'b0;
        upd_en     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                    state_next = S_CMP;
            end
            S_CMP:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (can_finish)
                begin
                    upd_en     = 1'b1;
                    req.ready  = 1'b1;
                    state_next = req.valid ? S_CMP : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        status_next = ST_OK;
        value_next  = '0;
        case (func_reg)
            FUNC_INSERT: status_next = hit ? ST_FAIL : (full ? ST_FULL : ST_OK);
            FUNC_REMOVE: status_next = hit ? ST_OK : ST_FAIL;
            FUNC_FIND:
            begin
                status_next = hit ? ST_OK : ST_FAIL;
                value_next  = hit ? found : '0;
            end
            default:     status_next = ST_OK;
        endcase
        out_valid_next = out_valid_reg;
        if (upd_en)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg    <= req.func;
            key_reg     <= req.key;
            payload_reg <= req.payload;
        end
        if (upd_en)
        begin
            status_reg <= status_next;
            value_reg  <= value_next;
        end
    end

    assign cmd.cmp_en  = (state_reg == S_CMP);
    assign cmd.upd_en  = upd_en;
    assign cmd.hit     = hit;
    assign cmd.full    = full;
    assign cmd.func    = func_reg;
    assign cmd.key     = key_reg;
    assign cmd.payload = payload_reg;

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.found_value = value_reg;

    // a result word appears only out of the update step
    `SKVT_ASSERT(a_out_from_upd, clk, rst_n, $rose(out_valid_reg) |-> $past(state_reg == S_UPD))
    // the compare step never takes a new word
    `SKVT_NEVER(a_no_accept_in_cmp, clk, rst_n, (state_reg == S_CMP) && req.ready)
    // a waiting result word keeps its value
    `SKVT_ASSERT(a_rsp_hold, clk, rst_n, (out_valid_reg && !rsp.ready) |=> $stable(value_reg))

endmodule
